// ===== rtl/lru_key_value_cache_top_macros.svh =====
// Assertion macros for the LRU key/value cache.
`ifndef LRU_KEY_VALUE_CACHE_TOP_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define LKC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("lru cache assertion failed");
// Check a property on every clock edge, reset included.
`define LKC_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) (prop)) \
        else $error("lru cache assertion failed");
`else
`define LKC_ASSERT(lbl, prop)
`define LKC_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== rtl/lru_kvc_pkg.sv =====
// Shared types and constants of the LRU key/value cache.
package lru_kvc_pkg;

    localparam int FUNC_W  = 2;
    localparam int KEY_W   = 8;
    localparam int VALUE_W = 32;
    localparam int CNT_W   = 5;
    localparam int IN_W    = 48;
    localparam int OUT_W   = 40;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_INSERT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RETRIEVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_EVICT    = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic signed [VALUE_W-1:0] value;
    } t_entry;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic commit;
    } t_cmd;

    // Datapath status
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] capacity;
    } t_sts;

endpackage

// ===== rtl/lru_kvc_ctrl.sv =====
// Controller: handshake and two-step sequencing of one operation.
module lru_kvc_ctrl
    import lru_kvc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    output t_cmd o_cmd
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_UPDATE = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic w_go;

    // Decode commands from the state
    always_comb begin
        o_s_tready    = (r_state == ST_IDLE);
        w_go          = !r_out_valid || i_m_tready;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        n_state       = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (w_go) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Hold the output beat until taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule

// ===== rtl/lru_kvc_dpath.sv =====
// Datapath: shift chain of entries with per-cell key compare.
module lru_kvc_dpath
    import lru_kvc_pkg::*;
#(
    parameter int DEPTH   = 16,
    parameter int CAP_RST = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    input  logic [FUNC_W-1:0]         i_func,
    input  logic [KEY_W-1:0]          i_key,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic                      i_cfg_wen,
    input  logic [CNT_W-1:0]          i_cfg_wdata,
    output logic                      o_found,
    output logic signed [VALUE_W-1:0] o_value,
    output logic [CNT_W-1:0]          o_occupancy,
    output t_sts                      o_sts
);

    t_entry                r_cell [DEPTH];
    t_entry                n_cell [DEPTH];
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_capacity;
    logic [CNT_W-1:0]      w_cap_wr;

    logic [FUNC_W-1:0]     r_func;
    logic [KEY_W-1:0]      r_key;
    logic signed [VALUE_W-1:0] r_value;
    logic [DEPTH-1:0]      r_hit, n_hit;
    logic [DEPTH-1:0]      r_mask, n_mask;
    logic                  r_found;

    t_entry                w_sel;
    t_entry                w_front;
    logic                  w_shift;
    logic                  w_found;
    logic signed [VALUE_W-1:0] w_vout;

    // Clamp a capacity write to 1..DEPTH
    always_comb begin
        w_cap_wr = i_cfg_wdata;
        if (w_cap_wr == '0) begin
            w_cap_wr = CNT_W'(1);
        end else if (int'(w_cap_wr) > DEPTH) begin
            w_cap_wr = CNT_W'(DEPTH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CNT_W'(CAP_RST);
        end else if (i_cfg_wen && r_count == '0) begin
            r_capacity <= w_cap_wr;
        end
    end

    // Compare the key against every live cell; mark cells that move back
    always_comb begin
        logic acc;
        acc = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            n_hit[i] = (i < int'(r_count)) && (r_cell[i].key == i_key);
        end
        for (int i = DEPTH - 1; i >= 0; i--) begin
            acc       = acc | n_hit[i];
            n_mask[i] = acc;
        end
        if (!acc) begin
            n_mask = '1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func  <= i_func;
            r_key   <= i_key;
            r_value <= i_value;
            r_hit   <= n_hit;
            r_mask  <= n_mask;
            r_found <= |n_hit;
        end
    end

    // Pick the hit cell
    always_comb begin
        w_sel = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (r_hit[i]) begin
                w_sel = w_sel | r_cell[i];
            end
        end
    end

    // Work out the shift, count and result of the operation
    always_comb begin
        w_front.key   = r_key;
        w_front.value = r_value;
        w_shift       = 1'b0;
        w_found       = 1'b0;
        w_vout        = '0;
        n_count       = r_count;
        case (r_func)
            FUNC_INSERT: begin
                w_shift = 1'b1;
                w_found = r_found;
                if (!r_found && r_count < r_capacity) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            FUNC_RETRIEVE: begin
                w_front = w_sel;
                w_shift = r_found;
                w_found = r_found;
                if (r_found) begin
                    w_vout = w_sel.value;
                end
            end
            FUNC_EVICT: begin
                if (r_count != '0) begin
                    w_found = 1'b1;
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
                w_shift = 1'b0;
            end
        endcase
        for (int i = 0; i < DEPTH; i++) begin
            n_cell[i] = r_cell[i];
        end
        if (w_shift) begin
            n_cell[0] = w_front;
            for (int i = 1; i < DEPTH; i++) begin
                if (r_mask[i]) begin
                    n_cell[i] = r_cell[i-1];
                end
            end
        end
    end

    // Advance the chain and load the output beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_cell[i] <= n_cell[i];
            end
            o_found     <= w_found;
            o_value     <= w_vout;
            o_occupancy <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.commit) begin
            r_count <= n_count;
        end
    end

    assign o_sts.count    = r_count;
    assign o_sts.capacity = r_capacity;

endmodule

// ===== rtl/lru_key_value_cache_top.sv =====
// Top level of the LRU key/value cache.
//
//  channel   dir  beat contents (low bits first)
//  s_axis    in   func[1:0], key[9:2], value_in[41:10], zero pad
//  m_axis    out  found[0], value_out[32:1], occupancy[37:33], zero pad
//  cfg       in   capacity, one write per cycle with i_cfg_wen
//
// Each operation has a compare and an update step: the accepting cycle compares
// the key against every cell of the chain, the update step shifts the chain and
// loads the output register. A stalled output holds the block in its update
// step. Reset empties the cache at once through the entry count; no sweep.
`include "lru_key_value_cache_top_macros.svh"
module lru_key_value_cache_top
    import lru_kvc_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // func[1:0], key[9:2], value_in[41:10]
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // found[0], value_out[32:1], occupancy[37:33]
    output logic [OUT_W-1:0] m_axis_tdata,
    input  logic             i_cfg_wen,
    input  logic [CNT_W-1:0] i_cfg_wdata
);

    localparam int CAP_RST = (DEPTH < 16) ? DEPTH : 16;

    t_cmd                      w_cmd;
    t_sts                      w_sts;
    logic                      w_found;
    logic signed [VALUE_W-1:0] w_value;
    logic [CNT_W-1:0]          w_occ;

    lru_kvc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_cmd      (w_cmd)
    );

    lru_kvc_dpath #(
        .DEPTH   (DEPTH),
        .CAP_RST (CAP_RST)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_func      (s_axis_tdata[1:0]),
        .i_key       (s_axis_tdata[9:2]),
        .i_value     (s_axis_tdata[41:10]),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .o_found     (w_found),
        .o_value     (w_value),
        .o_occupancy (w_occ),
        .o_sts       (w_sts)
    );

    assign m_axis_tdata = {2'b00, w_occ, w_value, w_found};

    // Occupancy never runs past the capacity in force
    `LKC_ASSERT(a_count_le_cap, w_sts.count <= w_sts.capacity)
    // A beat is committed only into a free or draining output register
    `LKC_ASSERT(a_commit_free, w_cmd.commit |-> (!m_axis_tvalid || m_axis_tready))
    // One operation at a time: no second beat right after an accepted one
    `LKC_ASSERT(a_one_at_a_time, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    // Capture and commit never fall in the same cycle
    `LKC_ASSERT_ALWAYS(a_cmd_exclusive, !(w_cmd.capture && w_cmd.commit))

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the LRU key/value cache: directed and random traffic against an in-bench cache predictor.
`timescale 1ns / 1ps
module testbench;
    import lru_kvc_pkg::*;

    localparam int          CACHE_DEPTH   = 16;
    localparam int          STALL_LIMIT   = 1000;
    localparam int          REPORT_LIMIT  = 10;
    localparam int          PHASE_ITEMS   = 150;
    localparam logic [1:0]  FUNC_NONE     = 2'd3;

    typedef struct {
        logic               found;
        logic signed [31:0] value;
        logic [4:0]         occupancy;
    } cache_reply_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    // func[1:0], key[9:2], value_in[41:10], zero pad
    logic [IN_W-1:0]   s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // found[0], value_out[32:1], occupancy[37:33], zero pad
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              i_cfg_wen = 1'b0;
    logic [CNT_W-1:0]  i_cfg_wdata = '0;

    // Predictor state: entries in recency order, most recent first
    t_entry            recency_list[$];
    int                capacity_now = CACHE_DEPTH;
    cache_reply_t      replies_due[$];

    int                mismatch_count = 0;
    int                idle_cycles = 0;
    bit                tx_gaps_on = 1'b1;
    bit                rx_stalls_on = 1'b1;
    int                rx_hold_cycles = 0;

    lru_key_value_cache_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one operation to the predicted cache and return its reply
    function automatic cache_reply_t lru_apply(logic [1:0] func, logic [7:0] key,
                                               logic signed [31:0] value);
        cache_reply_t reply;
        t_entry       hit;
        int           pos;
        reply.found = 1'b0;
        reply.value = '0;
        pos = -1;
        for (int i = 0; i < recency_list.size() && pos < 0; i++)
            if (recency_list[i].key == key)
                pos = i;
        case (func)
            FUNC_INSERT: begin
                if (pos >= 0) begin
                    reply.found = 1'b1;
                    recency_list.delete(pos);
                end else if (recency_list.size() >= capacity_now) begin
                    void'(recency_list.pop_back());
                end
                hit.key   = key;
                hit.value = value;
                recency_list.push_front(hit);
            end
            FUNC_RETRIEVE: begin
                if (pos >= 0) begin
                    hit = recency_list[pos];
                    recency_list.delete(pos);
                    recency_list.push_front(hit);
                    reply.found = 1'b1;
                    reply.value = hit.value;
                end
            end
            FUNC_EVICT: begin
                if (recency_list.size() > 0) begin
                    void'(recency_list.pop_back());
                    reply.found = 1'b1;
                end
            end
            default: ;
        endcase
        reply.occupancy = 5'(recency_list.size());
        return reply;
    endfunction

    // Predict on every input beat, take register writes, check every output beat
    always @(posedge i_clk) begin
        cache_reply_t want;
        if (i_rst_n) begin
            if (i_cfg_wen && recency_list.size() == 0)
                capacity_now = (i_cfg_wdata == 0) ? 1 :
                               (i_cfg_wdata > CACHE_DEPTH) ? CACHE_DEPTH : int'(i_cfg_wdata);
            if (s_axis_tvalid && s_axis_tready)
                replies_due.push_back(lru_apply(s_axis_tdata[1:0], s_axis_tdata[9:2],
                                                s_axis_tdata[41:10]));
            if (m_axis_tvalid && m_axis_tready) begin
                if (replies_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("unexpected beat: %h", m_axis_tdata);
                end else begin
                    want = replies_due.pop_front();
                    if (m_axis_tdata[0] !== want.found || m_axis_tdata[32:1] !== want.value ||
                        m_axis_tdata[37:33] !== want.occupancy) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("mismatch: found %b/%b value %h/%h occupancy %0d/%0d",
                                     want.found, m_axis_tdata[0], want.value,
                                     m_axis_tdata[32:1], want.occupancy, m_axis_tdata[37:33]);
                    end
                end
            end
        end
    end

    // Watchdog: end the run if no beat moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_wen)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("lru_key_value_cache_top test failed");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus a long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                rx_hold_cycles = rx_hold_cycles - 1;
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else if (rx_stalls_on && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                stall_left = $urandom_range(1, 12) - 1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Offer one beat, with an optional idle burst ahead of it, and wait for acceptance
    task automatic send_op(input logic [1:0] func, input logic [7:0] key,
                           input logic signed [31:0] value);
        int gap;
        if (tx_gaps_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 12);
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, value, key, func};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Drop valid and wait until every reply is back and the block is quiet
    task automatic settle_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CNT_W-1:0] cap);
        settle_idle();
        @(negedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= cap;
        @(negedge i_clk);
        i_cfg_wen   <= 1'b0;
    endtask

    // Evict until the predicted cache is empty
    task automatic drain_cache();
        int n;
        settle_idle();
        n = recency_list.size();
        repeat (n) send_op(FUNC_EVICT, 8'($urandom), $urandom);
    endtask

    task automatic send_random_op(input int key_base, input int key_span);
        logic [1:0]         func;
        logic [7:0]         key;
        logic signed [31:0] value;
        int                 pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            func = FUNC_INSERT;
        else if (pick < 85)
            func = FUNC_RETRIEVE;
        else if (pick < 96)
            func = FUNC_EVICT;
        else
            func = FUNC_NONE;
        // Mostly a narrow key pool so hits and replacements are common
        if ($urandom_range(0, 9) == 0)
            key = 8'($urandom_range(0, 255));
        else
            key = 8'(key_base + $urandom_range(0, key_span));
        case ($urandom_range(0, 15))
            0:       value = 32'sh8000_0000;
            1:       value = 32'sh7fff_ffff;
            2:       value = '0;
            3:       value = -1;
            default: value = $urandom;
        endcase
        send_op(func, key, value);
    endtask

    task automatic test_directed_ops();
        send_op(FUNC_EVICT, 8'h00, 0);
        send_op(FUNC_RETRIEVE, 8'h00, 0);
        send_op(FUNC_NONE, 8'hff, -1);
        send_op(FUNC_INSERT, 8'h00, 32'sh8000_0000);
        send_op(FUNC_INSERT, 8'hff, 32'sh7fff_ffff);
        send_op(FUNC_INSERT, 8'h5a, 0);
        send_op(FUNC_RETRIEVE, 8'hff, 0);
        send_op(FUNC_RETRIEVE, 8'h00, 0);
        send_op(FUNC_INSERT, 8'h00, -1);
        send_op(FUNC_RETRIEVE, 8'h00, 32'sh1234_5678);
        send_op(FUNC_RETRIEVE, 8'ha5, 0);
        send_op(FUNC_EVICT, 8'h00, 0);
        send_op(FUNC_RETRIEVE, 8'h5a, 0);
        send_op(FUNC_EVICT, 8'hff, -1);
        send_op(FUNC_EVICT, 8'h00, 0);
        send_op(FUNC_EVICT, 8'h00, 0);
    endtask

    task automatic test_capacity_bounds();
        // Zero is taken as one entry
        write_capacity(5'd0);
        send_op(FUNC_INSERT, 8'h11, 32'sh0000_0011);
        send_op(FUNC_INSERT, 8'h22, 32'sh0000_0022);
        send_op(FUNC_RETRIEVE, 8'h11, 0);
        send_op(FUNC_RETRIEVE, 8'h22, 0);
        // A write while entries are held must not take effect
        write_capacity(5'd3);
        send_op(FUNC_INSERT, 8'h33, 32'sh0000_0033);
        send_op(FUNC_RETRIEVE, 8'h22, 0);
        drain_cache();
        // Oversized value clamps to full depth
        write_capacity(5'd31);
        for (int k = 0; k <= CACHE_DEPTH; k++)
            send_op(FUNC_INSERT, 8'(k), $urandom);
        send_op(FUNC_RETRIEVE, 8'h00, 0);
        send_op(FUNC_RETRIEVE, 8'h01, 0);
        drain_cache();
    endtask

    task automatic test_random_traffic();
        logic [CNT_W-1:0] caps[8];
        int               eff;
        caps = '{5'd1, 5'd16, 5'd2, 5'd7, 5'd0, 5'd24, 5'd4, 5'd12};
        foreach (caps[p]) begin
            drain_cache();
            write_capacity(caps[p]);
            eff = (caps[p] == 0) ? 1 : (caps[p] > CACHE_DEPTH) ? CACHE_DEPTH : caps[p];
            begin
                int base;
                base = $urandom_range(0, 255);
                repeat (PHASE_ITEMS) send_random_op(base, eff + 3);
            end
        end
    endtask

    // Hold the output off while the sender keeps offering, so the input stalls
    task automatic test_output_hold_off();
        tx_gaps_on     = 1'b0;
        rx_hold_cycles = 150;
        repeat (30) send_random_op($urandom_range(0, 255), 10);
        tx_gaps_on     = 1'b1;
    endtask

    // Back-to-back traffic with no idling on either side
    task automatic test_steady_stream();
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        repeat (PHASE_ITEMS) send_random_op($urandom_range(0, 255), 18);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_ops();
        test_capacity_bounds();
        test_random_traffic();
        test_output_hold_off();
        test_steady_stream();

        settle_idle();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && replies_due.size() == 0)
            $display("lru_key_value_cache_top test passed");
        else
            $display("lru_key_value_cache_top test failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/lru_kvc_pkg.sv
rtl/lru_kvc_ctrl.sv
rtl/lru_kvc_dpath.sv
rtl/lru_key_value_cache_top.sv
dv/testbench.sv
